### hw/rtl/hkar_pkg.sv
// Shared types and constants of the HID key state / auto-repeat block.
// No dependencies.
package hkar_pkg;

	localparam int KEY_SLOTS_DEF       = 128;
	localparam int KEYS_PER_REPORT_DEF = 6;
	localparam int COUNT_WIDTH_DEF     = 8;

	localparam int         KEY_FIELDS  = 6;
	localparam int         MAP_WORD_W  = 64;
	localparam logic [7:0] FIRST_KEY   = 8'd4;
	localparam logic [7:0] DELAY_RESET = 8'd3;

	localparam logic MODE_REPORT = 1'b0;
	localparam logic MODE_TICK   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic done;
		logic hit;
	} walk_stat_t;

endpackage

### hw/rtl/hkar_req_if.sv
// Request channel: report or repeat tick word.
// Depends on nothing.
interface hkar_req_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] modifiers;
	logic [7:0] key_0;
	logic [7:0] key_1;
	logic [7:0] key_2;
	logic [7:0] key_3;
	logic [7:0] key_4;
	logic [7:0] key_5;

	modport source (output valid, mode, modifiers, key_0, key_1, key_2, key_3, key_4, key_5,
		input ready);
	modport sink (input valid, mode, modifiers, key_0, key_1, key_2, key_3, key_4, key_5,
		output ready);
endinterface

### hw/rtl/hkar_rsp_if.sv
// Response channel: key state word after each request.
// Depends on nothing.
interface hkar_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  modifier_state;
	logic [63:0] pressed_low;
	logic [63:0] pressed_high;
	logic        any_down;
	logic        repeat_running;
	logic [31:0] update_count;

	modport source (output valid, modifier_state, pressed_low, pressed_high, any_down,
		repeat_running, update_count, input ready);
	modport sink (input valid, modifier_state, pressed_low, pressed_high, any_down,
		repeat_running, update_count, output ready);
endinterface

### hw/rtl/hkar_repeat_walk.sv
// Repeat counter memory and the sequential walk run on every tick.
// Depends on hkar_pkg.
module hkar_repeat_walk import hkar_pkg::*; #(
	parameter int KEY_SLOTS   = KEY_SLOTS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [7:0]           hold_delay,
	input  logic [KEY_SLOTS-1:0] held_map,
	input  logic [KEY_SLOTS-1:0] fresh_map,
	output walk_stat_t           stat
);
	localparam int IDX_W = $clog2(KEY_SLOTS);
	localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] cnt_mem [KEY_SLOTS];

	logic             issue_q;
	logic [IDX_W-1:0] addr_q;

	logic                   vld_s1;
	logic                   last_s1;
	logic                   held_s1;
	logic                   fresh_s1;
	logic [IDX_W-1:0]       addr_s1;
	logic [COUNT_WIDTH-1:0] rd_data_s1;

	logic [COUNT_WIDTH-1:0] cur_cnt;
	logic [COUNT_WIDTH-1:0] nxt_cnt;
	logic                   wr_en;
	logic                   addr_last;

	assign addr_last = (addr_q == IDX_W'(KEY_SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			addr_q  <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			vld_s1  <= issue_q;
			last_s1 <= issue_q && addr_last;
			if (start) begin
				issue_q <= 1'b1;
				addr_q  <= '0;
			end else if (issue_q) begin
				if (addr_last) begin
					issue_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1  <= addr_q;
		held_s1  <= held_map[addr_q];
		fresh_s1 <= fresh_map[addr_q];
	end

	// read at walk address, write back one entry behind
	always_ff @(posedge clk) begin
		if (issue_q) begin
			rd_data_s1 <= cnt_mem[addr_q];
		end
		if (wr_en) begin
			cnt_mem[addr_s1] <= nxt_cnt;
		end
	end

	// a key pressed since the last tick starts from zero
	assign cur_cnt = fresh_s1 ? '0 : rd_data_s1;
	assign nxt_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
	assign wr_en   = vld_s1 && held_s1;

	assign stat.done = vld_s1 && last_s1;
	assign stat.hit  = wr_en && (CMP_W'(nxt_cnt) > CMP_W'(hold_delay));

endmodule

### hw/rtl/hid_key_state_autorepeat.sv
// HID boot keyboard key state tracker with typematic repeat counting.
// Depends on hkar_pkg, hkar_req_if, hkar_rsp_if, hkar_repeat_walk.
//
//   channel  dir  handshake     word
//   req      in   valid/ready   mode, modifiers, key_0..key_5
//   rsp      out  valid/ready   modifier_state, pressed_low/high, any_down,
//                               repeat_running, update_count
//   cfg      in   cfg_wr_en     hold delay (cfg_wr_data)
//
// One request at a time; req.ready is high only when idle.
// Report: accept goes straight to the result load step, which registers rsp.valid.
// Tick: accept starts the walk over all KEY_SLOTS counters, then the result load step;
// the walk does one counter memory read-modify-write per cycle.
// A stalled rsp holds the result; the next request is taken meanwhile and
// waits in the result load step until the output register frees.
// Reset is asynchronous; no memory clearing pass is needed.
module hid_key_state_autorepeat import hkar_pkg::*; #(
	parameter int KEY_SLOTS       = KEY_SLOTS_DEF,
	parameter int KEYS_PER_REPORT = KEYS_PER_REPORT_DEF,
	parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	hkar_req_if.sink   req,
	hkar_rsp_if.source rsp
);
	localparam int IDX_W = $clog2(KEY_SLOTS);
	localparam int NKEY  = (KEYS_PER_REPORT < KEY_FIELDS) ? KEYS_PER_REPORT : KEY_FIELDS;
	localparam int PAD_W = (KEY_SLOTS > 2 * MAP_WORD_W) ? KEY_SLOTS : 2 * MAP_WORD_W;

	state_t state_q;

	logic [7:0]           delay_q;
	logic [KEY_SLOTS-1:0] map_q;
	logic [KEY_SLOTS-1:0] fresh_q;
	logic [7:0]           mod_q;
	logic [31:0]          event_q;
	logic                 rsp_valid_q;

	logic [7:0]           keys [KEY_FIELDS];
	logic [KEY_SLOTS-1:0] new_map;
	logic [PAD_W-1:0]     map_pad;
	logic                 req_fire;
	logic                 walk_start;
	logic                 emit_go;
	walk_stat_t           walk_stat;

	assign keys[0] = req.key_0;
	assign keys[1] = req.key_1;
	assign keys[2] = req.key_2;
	assign keys[3] = req.key_3;
	assign keys[4] = req.key_4;
	assign keys[5] = req.key_5;

	always_comb begin
		new_map = '0;
		for (int i = 0; i < NKEY; i++) begin
			if (keys[i] >= FIRST_KEY && {1'b0, keys[i]} < 9'(KEY_SLOTS)) begin
				new_map[keys[i][IDX_W-1:0]] = 1'b1;
			end
		end
	end

	assign req.ready  = (state_q == ST_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign walk_start = req_fire && (req.mode == MODE_TICK);
	assign emit_go    = (state_q == ST_EMIT) && (!rsp_valid_q || rsp.ready);
	assign map_pad    = PAD_W'(map_q);

	hkar_repeat_walk #(
		.KEY_SLOTS   (KEY_SLOTS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (walk_start),
		.hold_delay   (delay_q),
		.held_map     (map_q),
		.fresh_map    (fresh_q),
		.stat         (walk_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
		end else if (cfg_wr_en) begin
			delay_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			map_q   <= '0;
			fresh_q <= '0;
			mod_q   <= '0;
			event_q <= '0;
		end else begin
			if (walk_stat.hit) begin
				event_q <= event_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.mode == MODE_REPORT) begin
							map_q   <= new_map;
							fresh_q <= fresh_q | (new_map & ~map_q);
							mod_q   <= req.modifiers;
							event_q <= event_q + 1'b1;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (walk_stat.done) begin
						fresh_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			rsp.modifier_state <= mod_q;
			rsp.pressed_low    <= map_pad[MAP_WORD_W-1:0];
			rsp.pressed_high   <= map_pad[2*MAP_WORD_W-1:MAP_WORD_W];
			rsp.any_down       <= |map_q;
			rsp.repeat_running <= |map_q;
			rsp.update_count   <= event_q;
		end
	end

	assign rsp.valid = rsp_valid_q;

endmodule

### hw/rtl/hkar_checker.sv
// Port-level checks of hid_key_state_autorepeat, attached by bind.
// Depends on hid_key_state_autorepeat, the bind target.
module hkar_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [7:0]  rsp_modifier_state,
	input logic [63:0] rsp_pressed_low,
	input logic [63:0] rsp_pressed_high,
	input logic        rsp_any_down,
	input logic        rsp_repeat_running,
	input logic [31:0] rsp_update_count
);

	// one request in flight: busy right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req ready right after accept");

	a_running_follows_down: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_any_down == rsp_repeat_running)
		else $error("repeat_running differs from any_down");

	a_bitmap_down: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_pressed_low != 64'd0 || rsp_pressed_high != 64'd0) |-> rsp_any_down)
		else $error("keys in bitmap but any_down low");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_update_count)
			&& $stable(rsp_modifier_state) && $stable(rsp_pressed_low)
			&& $stable(rsp_pressed_high))
		else $error("stalled rsp word changed");

endmodule

bind hid_key_state_autorepeat hkar_checker u_hkar_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_modifier_state (rsp.modifier_state),
	.rsp_pressed_low    (rsp.pressed_low),
	.rsp_pressed_high   (rsp.pressed_high),
	.rsp_any_down       (rsp.any_down),
	.rsp_repeat_running (rsp.repeat_running),
	.rsp_update_count   (rsp.update_count)
);

### verif/hkar_tb_pkg.sv
`timescale 1ns / 1ps
// Testbench types and the key state tracker class for hid_key_state_autorepeat.
// Depends on hkar_pkg for block sizes, mode codes and the delay reset value.
package hkar_tb_pkg;
	import hkar_pkg::*;

	localparam int SLOTS       = KEY_SLOTS_DEF;
	localparam int REPORT_KEYS = (KEYS_PER_REPORT_DEF < KEY_FIELDS) ? KEYS_PER_REPORT_DEF
		: KEY_FIELDS;

	typedef struct packed {
		logic            mode;
		logic [7:0]      modifiers;
		logic [5:0][7:0] keys;
	} key_req_t;

	typedef struct packed {
		logic [7:0]  modifier_state;
		logic [63:0] pressed_low;
		logic [63:0] pressed_high;
		logic        any_down;
		logic        repeat_running;
		logic [31:0] update_count;
	} key_state_t;

	class key_tracker_check;
		logic [2*MAP_WORD_W-1:0]  pressed;
		logic [COUNT_WIDTH_DEF-1:0] hold_ticks [SLOTS];
		logic [7:0]               modifier;
		logic [31:0]              events;
		logic [7:0]               delay;
		key_state_t               pending_states [$];
		int                       reports;
		int                       ticks;
		int                       checked;
		int                       errors;

		function new();
			pressed  = '0;
			modifier = '0;
			events   = '0;
			delay    = DELAY_RESET;
			foreach (hold_ticks[k])
				hold_ticks[k] = '0;
			reports = 0;
			ticks   = 0;
			checked = 0;
			errors  = 0;
		endfunction

		function void set_delay(logic [7:0] v);
			delay = v;
		endfunction

		function int outstanding();
			return pending_states.size();
		endfunction

		function void note_word(key_req_t w);
			logic [2*MAP_WORD_W-1:0] prev;
			int                      code;
			key_state_t              s;
			if (w.mode == MODE_TICK) begin
				for (int k = 0; k < SLOTS; k++) begin
					if (pressed[k]) begin
						if (hold_ticks[k] != '1)
							hold_ticks[k] = hold_ticks[k] + 1'b1;
						if (hold_ticks[k] > delay)
							events = events + 1;
					end else begin
						hold_ticks[k] = '0;
					end
				end
				ticks++;
			end else begin
				prev     = pressed;
				pressed  = '0;
				modifier = w.modifiers;
				for (int i = 0; i < REPORT_KEYS; i++) begin
					code = w.keys[i];
					if (code >= FIRST_KEY && code < SLOTS) begin
						if (!prev[code])
							hold_ticks[code] = '0;
						pressed[code] = 1'b1;
					end
				end
				events = events + 1;
				reports++;
			end
			s.modifier_state = modifier;
			s.pressed_low    = pressed[MAP_WORD_W-1:0];
			s.pressed_high   = pressed[2*MAP_WORD_W-1:MAP_WORD_W];
			s.any_down       = |pressed;
			s.repeat_running = |pressed;
			s.update_count   = events;
			pending_states.push_back(s);
		endfunction

		function void check_word(key_state_t act);
			key_state_t exp;
			if (pending_states.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected rsp word: cnt=%h any=%b", act.update_count,
						act.any_down);
				return;
			end
			exp = pending_states.pop_front();
			checked++;
			if (act.modifier_state !== exp.modifier_state || act.pressed_low !== exp.pressed_low
					|| act.pressed_high !== exp.pressed_high || act.any_down !== exp.any_down
					|| act.repeat_running !== exp.repeat_running
					|| act.update_count !== exp.update_count) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch on word %0d", checked);
					$display("  exp mod=%h lo=%h hi=%h any=%b run=%b cnt=%h", exp.modifier_state,
						exp.pressed_low, exp.pressed_high, exp.any_down, exp.repeat_running,
						exp.update_count);
					$display("  got mod=%h lo=%h hi=%h any=%b run=%b cnt=%h", act.modifier_state,
						act.pressed_low, act.pressed_high, act.any_down, act.repeat_running,
						act.update_count);
				end
			end
		endfunction
	endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the hid_key_state_autorepeat testbench: clock, reset, stimulus and checking.
// Depends on hkar_pkg, hkar_tb_pkg, hkar_req_if, hkar_rsp_if and the block itself.
module tb_top;
	import hkar_pkg::*;
	import hkar_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 800000;
	localparam int DRAIN_CYCLES = KEY_SLOTS_DEF + 16;

	logic            clk         = 1'b0;
	logic            arst_n      = 1'b0;
	logic            cfg_wr_en   = 1'b0;
	logic [7:0]      cfg_wr_data = '0;
	int unsigned     cycles      = 0;
	bit              calm        = 1'b0;
	logic [5:0][7:0] held_keys   = '0;
	logic [7:0]      mid_delay   = '0;

	key_tracker_check tracker = new();

	hkar_req_if req();
	hkar_rsp_if rsp();

	hid_key_state_autorepeat uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.rsp         (rsp)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[hid_key_state_autorepeat] ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(20, 70);
	endfunction

	function automatic key_req_t mk(logic m, logic [7:0] mods, logic [7:0] k0, logic [7:0] k1,
			logic [7:0] k2, logic [7:0] k3, logic [7:0] k4, logic [7:0] k5);
		key_req_t w;
		w.mode      = m;
		w.modifiers = mods;
		w.keys      = {k5, k4, k3, k2, k1, k0};
		return w;
	endfunction

	function automatic key_req_t random_word(int tick_pct);
		key_req_t w;
		int       r;
		w.mode      = MODE_REPORT;
		w.modifiers = 8'($urandom_range(0, 255));
		for (int i = 0; i < KEY_FIELDS; i++)
			w.keys[i] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < tick_pct) begin
			w.mode = MODE_TICK;
			return w;
		end
		r = $urandom_range(0, 99);
		if (r < 10)
			return w;
		if (r < 18) begin
			for (int i = 0; i < KEY_FIELDS; i++)
				w.keys[i] = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
					: 8'($urandom_range(128, 255));
		end else begin
			for (int i = 0; i < KEY_FIELDS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 65)
					w.keys[i] = held_keys[i];
				else if (r < 85)
					w.keys[i] = 8'($urandom_range(FIRST_KEY, KEY_SLOTS_DEF - 1));
				else if (r < 95)
					w.keys[i] = 8'($urandom_range(0, FIRST_KEY - 1));
				else
					w.keys[i] = 8'($urandom_range(KEY_SLOTS_DEF, 255));
			end
			if ($urandom_range(0, 9) == 0)
				w.keys[$urandom_range(0, 5)] = w.keys[$urandom_range(0, 5)];
		end
		held_keys = w.keys;
		return w;
	endfunction

	task automatic send_word(key_req_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.mode      <= w.mode;
		req.modifiers <= w.modifiers;
		req.key_0     <= w.keys[0];
		req.key_1     <= w.keys[1];
		req.key_2     <= w.keys[2];
		req.key_3     <= w.keys[3];
		req.key_4     <= w.keys[4];
		req.key_5     <= w.keys[5];
		do
			@(posedge clk);
		while (!req.ready);
		tracker.note_word(w);
	endtask

	task automatic settle();
		req.valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_delay(logic [7:0] v);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_delay(v);
	endtask

	task automatic run_random(int count, int tick_pct);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			send_word(random_word(tick_pct));
		end
		calm = 1'b0;
	endtask

	initial begin : rsp_side
		int         stall;
		key_state_t got;
		stall = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				got.modifier_state = rsp.modifier_state;
				got.pressed_low    = rsp.pressed_low;
				got.pressed_high   = rsp.pressed_high;
				got.any_down       = rsp.any_down;
				got.repeat_running = rsp.repeat_running;
				got.update_count   = rsp.update_count;
				tracker.check_word(got);
			end
			if (stall == 0 && $urandom_range(0, 99) < 25)
				stall = pick_gap();
			if (stall > 0) begin
				stall--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin : req_side
		req.valid     <= 1'b0;
		req.mode      <= MODE_REPORT;
		req.modifiers <= '0;
		req.key_0     <= '0;
		req.key_1     <= '0;
		req.key_2     <= '0;
		req.key_3     <= '0;
		req.key_4     <= '0;
		req.key_5     <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset delay
		send_word(mk(MODE_TICK, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_word(mk(MODE_REPORT, 8'hff, 8'd4, 8'd127, 8'd0, 8'd3, 8'd128, 8'd255));
		send_word(mk(MODE_REPORT, 8'h00, 8'd4, 8'd4, 8'd4, 8'd127, 8'd127, 8'd1));
		repeat (5)
			send_word(mk(MODE_TICK, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		send_word(mk(MODE_REPORT, 8'h08, 8'd4, 8'd63, 8'd64, 8'd2, 8'd2, 8'd2));
		repeat (2)
			send_word(mk(MODE_TICK, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_word(mk(MODE_REPORT, 8'ha5, 8'd5, 8'd6, 8'd62, 8'd63, 8'd64, 8'd65));
		send_word(mk(MODE_TICK, 8'h5a, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9));
		send_word(mk(MODE_REPORT, 8'h5a, 8'd0, 8'd1, 8'd2, 8'd3, 8'd0, 8'd3));
		send_word(mk(MODE_TICK, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_word(mk(MODE_REPORT, 8'h3c, 8'd128, 8'd200, 8'd255, 8'd129, 8'd130, 8'd131));
		send_word(mk(MODE_REPORT, 8'h01, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		repeat (4)
			send_word(mk(MODE_TICK, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		// release then re-press: counter restarts
		send_word(mk(MODE_REPORT, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_word(mk(MODE_REPORT, 8'h00, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_word(mk(MODE_TICK, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

		write_delay(8'd0);
		run_random(100, 45);

		// long hold at the top delay: counters reach saturation
		write_delay(8'd254);
		send_word(mk(MODE_REPORT, 8'h81, 8'd4, 8'd127, 8'd50, 8'd0, 8'd0, 8'd0));
		for (int i = 0; i < 262; i++) begin
			if (i % 60 == 30)
				send_word(mk(MODE_REPORT, 8'($urandom_range(0, 255)), 8'd4, 8'd127, 8'd50,
					8'($urandom_range(5, 126)), 8'd0, 8'd0));
			else
				send_word(random_word(100));
		end

		mid_delay = 8'($urandom_range(1, 253));
		write_delay(mid_delay);
		run_random(90, 50);
		write_delay(8'd1);
		run_random(60, 45);
		write_delay(DELAY_RESET);
		run_random(40, 50);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("ran %0d reports and %0d ticks, %0d result words checked", tracker.reports,
			tracker.ticks, tracker.checked);
		$display("hold delay settings: %0d, 0, 254, %0d, 1, %0d", DELAY_RESET, mid_delay,
			DELAY_RESET);
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("[hid_key_state_autorepeat] OK");
		else
			$display("[hid_key_state_autorepeat] ERROR");
		$finish;
	end

endmodule
